### design/stl_pkg.sv
`default_nettype none

package stl_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int KEY_W     = 64;
    localparam int TIME_W    = 32;
    localparam int HIT_W     = 4;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_ATTACH = 2'd1,
        OP_DELETE = 2'd2,
        OP_TOUCH  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              key_we;
        logic              time_we;
        logic [SLOT_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_key;
        logic [TIME_W-1:0] wr_time;
    } mem_req_t;

    typedef struct packed {
        logic             status;
        logic [HIT_W-1:0] hit_slot;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } result_t;

endpackage

`default_nettype wire

### design/stl_mem.sv
`default_nettype none

module stl_mem
    import stl_pkg::*;
(
    input  wire logic              clk,
    input  wire mem_req_t          req,
    output logic      [KEY_W-1:0]  rd_key,
    output logic      [TIME_W-1:0] rd_time
);

    logic [KEY_W-1:0]  key_mem  [NUM_SLOTS];
    logic [TIME_W-1:0] time_mem [NUM_SLOTS];
    logic [KEY_W-1:0]  rd_key_reg;
    logic [TIME_W-1:0] rd_time_reg;

    always_ff @(posedge clk)
    begin
        if (req.key_we)
        begin
            key_mem[req.wr_addr] <= req.wr_key;
        end
        if (req.time_we)
        begin
            time_mem[req.wr_addr] <= req.wr_time;
        end
        if (req.rd_en)
        begin
            rd_key_reg  <= key_mem[req.rd_addr];
            rd_time_reg <= time_mem[req.rd_addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_time = rd_time_reg;

endmodule

`default_nettype wire

### design/stl_seq.sv
`default_nettype none

module stl_seq
    import stl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [KEY_W-1:0]  session_key,
    input  wire logic [HIT_W-1:0]  slot_index,
    input  wire logic [TIME_W-1:0] now_time,
    output mem_req_t               mem_req,
    input  wire logic [KEY_W-1:0]  rd_key,
    input  wire logic [TIME_W-1:0] rd_time,
    input  wire logic              out_busy,
    output logic                   res_load,
    output result_t                res
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 cmp_en_reg, cmp_en_next;
    logic [SLOT_W-1:0]    cmp_idx_reg;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;

    func_t             op_func_reg;
    logic [KEY_W-1:0]  op_key_reg;
    logic [HIT_W-1:0]  op_idx_reg;
    logic [TIME_W-1:0] op_time_reg;

    logic              found_reg, found_next;
    logic [SLOT_W-1:0] found_idx_reg, found_idx_next;
    logic              best_set_reg, best_set_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    logic [TIME_W-1:0] best_time_reg, best_time_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;

    logic accept;
    logic scan_more;
    logic cmp_valid;
    logic key_eq;
    logic time_lt;
    logic touch_ok;

    assign accept    = in_valid && !in_stall;
    assign scan_more = (cnt_reg != CNT_W'(NUM_SLOTS));
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign key_eq    = (rd_key == op_key_reg);
    assign time_lt   = (rd_time < best_time_reg);
    assign touch_ok  = (32'(op_idx_reg) < NUM_SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            cmp_en_reg <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cmp_en_reg <= cmp_en_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cnt_reg[SLOT_W-1:0];
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        best_set_reg  <= best_set_next;
        best_idx_reg  <= best_idx_next;
        best_time_reg <= best_time_next;
        best_key_reg  <= best_key_next;
        if (accept)
        begin
            op_func_reg <= func_t'(func);
            op_key_reg  <= session_key;
            op_idx_reg  <= slot_index;
            op_time_reg <= now_time;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmp_en_next    = 1'b0;
        valid_next     = valid_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        best_set_next  = best_set_reg;
        best_idx_next  = best_idx_reg;
        best_time_next = best_time_reg;
        best_key_next  = best_key_reg;
        in_stall       = (state_reg != ST_IDLE);
        res_load       = 1'b0;
        res            = '0;

        mem_req         = '0;
        mem_req.rd_addr = cnt_reg[SLOT_W-1:0];
        mem_req.wr_addr = found_idx_reg;
        mem_req.wr_key  = op_key_reg;
        mem_req.wr_time = op_time_reg;

        // one slot compared per cycle, in the cycle after its read address is issued
        if (cmp_en_reg)
        begin
            if (op_func_reg == OP_CREATE)
            begin
                if (!cmp_valid && !found_reg)
                begin
                    found_next     = 1'b1;
                    found_idx_next = cmp_idx_reg;
                end
                if (cmp_valid && (!best_set_reg || time_lt))
                begin
                    best_set_next  = 1'b1;
                    best_idx_next  = cmp_idx_reg;
                    best_time_next = rd_time;
                    best_key_next  = rd_key;
                end
            end
            else if (cmp_valid && key_eq && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    best_set_next = 1'b0;
                    state_next    = (func_t'(func) == OP_TOUCH) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_more)
                begin
                    mem_req.rd_en = 1'b1;
                    cmp_en_next   = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_busy)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (op_func_reg)
                        OP_CREATE:
                        begin
                            mem_req.key_we  = 1'b1;
                            mem_req.time_we = 1'b1;
                            if (found_reg)
                            begin
                                mem_req.wr_addr = found_idx_reg;
                                res.hit_slot    = HIT_W'(found_idx_reg);
                            end
                            else
                            begin
                                mem_req.wr_addr = best_idx_reg;
                                res.hit_slot    = HIT_W'(best_idx_reg);
                                res.evicted     = 1'b1;
                                res.evicted_key = best_key_reg;
                            end
                            valid_next[mem_req.wr_addr] = 1'b1;
                        end
                        OP_ATTACH, OP_DELETE:
                        begin
                            if (found_reg)
                            begin
                                res.hit_slot = HIT_W'(found_idx_reg);
                                if (op_func_reg == OP_ATTACH)
                                begin
                                    mem_req.time_we = 1'b1;
                                end
                                else
                                begin
                                    valid_next[found_idx_reg] = 1'b0;
                                end
                            end
                            else
                            begin
                                res.status = 1'b1;
                            end
                        end
                        OP_TOUCH:
                        begin
                            if (touch_ok)
                            begin
                                mem_req.time_we = 1'b1;
                                mem_req.wr_addr = SLOT_W'(op_idx_reg);
                                res.hit_slot    = op_idx_reg;
                            end
                            else
                            begin
                                res.status = 1'b1;
                            end
                        end
                        default:
                        begin
                            res.status = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/session_table_lru_unit.sv
`default_nettype none

// Session table with NUM_SLOTS slots (valid bit, 64-bit key, 32-bit access
// time). Create, attach and delete walk every slot through one key/time
// comparator, one slot per cycle, out of a registered-read memory. Touch
// addresses its slot directly without a walk. in_stall is high from
// acceptance until the result is loaded into the output register; the next
// transaction is taken while a result still waits on out_stall.

module session_table_lru_unit
    import stl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [KEY_W-1:0]  session_key,
    input  wire logic [HIT_W-1:0]  slot_index,
    input  wire logic [TIME_W-1:0] now_time,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   status,
    output logic      [HIT_W-1:0]  hit_slot,
    output logic                   evicted,
    output logic      [KEY_W-1:0]  evicted_key
);

    mem_req_t          mem_req;
    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] rd_time;
    logic              res_load;
    result_t           res;
    logic              out_busy;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    assign out_busy = out_valid_reg && out_stall;

    stl_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .session_key (session_key),
        .slot_index  (slot_index),
        .now_time    (now_time),
        .mem_req     (mem_req),
        .rd_key      (rd_key),
        .rd_time     (rd_time),
        .out_busy    (out_busy),
        .res_load    (res_load),
        .res         (res)
    );

    stl_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_key  (rd_key),
        .rd_time (rd_time)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign hit_slot    = out_res_reg.hit_slot;
    assign evicted     = out_res_reg.evicted;
    assign evicted_key = out_res_reg.evicted_key;

    // a transaction in flight keeps the input side closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a transaction is in flight");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled result");

    // not found reports slot zero and no eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (hit_slot == '0 && !evicted && evicted_key == '0))
        else $error("not-found result carries slot or eviction data");

    // a loaded result shows up as valid on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

### verif/session_table_lru_unit_test.sv
`timescale 1ns / 100ps

module session_table_lru_unit_test;
    import stl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Mirror of the slot table plus the queue of results still owed by the block.
    class slot_table_tracker;
        logic              live   [NUM_SLOTS];
        logic [KEY_W-1:0]  key_of [NUM_SLOTS];
        logic [TIME_W-1:0] stamp  [NUM_SLOTS];
        result_t           owed_results[$];
        int                mismatch_count;

        function new();
            foreach (live[i])
            begin
                live[i]   = 1'b0;
                key_of[i] = '0;
                stamp[i]  = '0;
            end
            mismatch_count = 0;
        endfunction

        function void apply_op(func_t op, logic [KEY_W-1:0] k, logic [HIT_W-1:0] idx,
                               logic [TIME_W-1:0] t);
            result_t r;
            int      s;
            r = '0;
            s = -1;
            case (op)
                OP_CREATE:
                begin
                    for (int i = 0; i < NUM_SLOTS && s < 0; i++)
                        if (!live[i])
                            s = i;
                    // table full: oldest stamp goes, lowest index on a tie
                    if (s < 0)
                    begin
                        s = 0;
                        for (int i = 1; i < NUM_SLOTS; i++)
                            if (stamp[i] < stamp[s])
                                s = i;
                        r.evicted     = 1'b1;
                        r.evicted_key = key_of[s];
                    end
                    live[s]    = 1'b1;
                    key_of[s]  = k;
                    stamp[s]   = t;
                    r.hit_slot = HIT_W'(s);
                end
                OP_ATTACH, OP_DELETE:
                begin
                    for (int i = 0; i < NUM_SLOTS && s < 0; i++)
                        if (live[i] && key_of[i] == k)
                            s = i;
                    if (s < 0)
                        r.status = 1'b1;
                    else
                    begin
                        if (op == OP_ATTACH)
                            stamp[s] = t;
                        else
                            live[s] = 1'b0;
                        r.hit_slot = HIT_W'(s);
                    end
                end
                default:
                begin
                    // touch writes the stamp even on an empty slot
                    if (int'(idx) < NUM_SLOTS)
                    begin
                        stamp[idx] = t;
                        r.hit_slot = idx;
                    end
                    else
                        r.status = 1'b1;
                end
            endcase
            owed_results.push_back(r);
        endfunction

        function void flag(string what, result_t want, result_t got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%s: expected status %0d hit %0d evicted %0d key %h, got %0d %0d %0d %h",
                         what, want.status, want.hit_slot, want.evicted, want.evicted_key,
                         got.status, got.hit_slot, got.evicted, got.evicted_key);
        endfunction

        function void compare_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                flag("unexpected result", '0, got);
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status || got.hit_slot !== want.hit_slot ||
                got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
                flag("result differs", want, got);
        endfunction
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [1:0]        func        = OP_CREATE;
    logic [KEY_W-1:0]  session_key = '0;
    logic [HIT_W-1:0]  slot_index  = '0;
    logic [TIME_W-1:0] now_time    = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic              status;
    logic [HIT_W-1:0]  hit_slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;

    slot_table_tracker tracker;
    logic [KEY_W-1:0]  known_keys[$];
    bit                idle_on = 1'b1;
    int unsigned       cycle_count = 0;

    session_table_lru_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .session_key (session_key),
        .slot_index  (slot_index),
        .now_time    (now_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .hit_slot    (hit_slot),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("session_table_lru_unit: mismatch");
            $finish;
        end
    end

    // Values read here are the ones present before this edge's updates.
    always @(posedge clk)
    begin
        if (rst_n && in_valid === 1'b1 && in_stall === 1'b0)
            tracker.apply_op(func_t'(func), session_key, slot_index, now_time);
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            tracker.compare_result(result_t'({status, hit_slot, evicted, evicted_key}));
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_op(func_t op, logic [KEY_W-1:0] k, logic [HIT_W-1:0] idx,
                           logic [TIME_W-1:0] t);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        session_key <= k;
        slot_index  <= idx;
        now_time    <= t;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Reuses a key already handed out at reuse_pct odds so lookups hit; the rest fresh or extreme.
    function automatic logic [KEY_W-1:0] pick_key(int reuse_pct);
        if (known_keys.size() != 0 && $urandom_range(0, 99) < reuse_pct)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int                op_pick;
        int                time_mode;
        func_t             op;
        logic [KEY_W-1:0]  k;
        logic [TIME_W-1:0] clock_now;
        logic [TIME_W-1:0] t;

        tracker   = new();
        clock_now = 32'd300;
        time_mode = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero key must not match the cleared slots left by reset
        send_op(OP_ATTACH, '0, 4'd0, 32'd1);
        send_op(OP_DELETE, '1, 4'd15, 32'd1);
        send_op(OP_TOUCH, '1, 4'd15, '1);
        send_op(OP_TOUCH, '0, 4'd0, '0);
        send_op(OP_CREATE, '0, 4'd0, 32'd100);
        send_op(OP_CREATE, '1, 4'd0, '1);
        // duplicate key lands in its own slot
        send_op(OP_CREATE, '0, 4'd0, 32'd100);
        send_op(OP_ATTACH, '0, 4'd0, 32'd100);
        // delete drops only the valid bit; next attach must skip to slot 2
        send_op(OP_DELETE, '0, 4'd0, 32'd7);
        send_op(OP_ATTACH, '0, 4'd0, 32'd100);
        send_op(OP_CREATE, 64'h0123_4567_89AB_CDEF, 4'd0, 32'd100);
        for (int i = 3; i < NUM_SLOTS; i++)
            send_op(OP_CREATE, {32'hA5A5_0000 + i, $urandom}, 4'd0, 32'd100);
        // full table, many slots tied at the oldest stamp
        send_op(OP_CREATE, 64'hFEDC_BA98_7654_3210, 4'd0, 32'd200);
        send_op(OP_CREATE, 64'h8000_0000_0000_0001, 4'd0, 32'd0);

        for (int n = 0; n < 1800; n++)
        begin
            if (n % 100 == 0)
                time_mode = $urandom_range(0, 2);
            if (n % 300 == 0)
                idle_on = (n < 1500) && ((n / 300) % 2 == 0 || $urandom_range(0, 1) == 1);
            case (time_mode)
                0:
                begin
                    clock_now = clock_now + $urandom_range(0, 3);
                    t = clock_now;
                end
                1: t = $urandom;
                default: t = $urandom_range(0, 3);
            endcase
            op_pick = $urandom_range(0, 99);
            if (op_pick < 30)
            begin
                op = OP_CREATE;
                k  = pick_key(20);
                known_keys.push_back(k);
                if (known_keys.size() > 24)
                    void'(known_keys.pop_front());
            end
            else
            begin
                op = (op_pick < 60) ? OP_ATTACH : (op_pick < 80) ? OP_DELETE : OP_TOUCH;
                k  = pick_key(80);
            end
            send_op(op, k, HIT_W'($urandom_range(0, 15)), t);
        end
        in_valid <= 1'b0;

        while (tracker.owed_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.owed_results.size() == 0)
            $display("session_table_lru_unit: match");
        else
            $display("session_table_lru_unit: mismatch");
        $finish;
    end

endmodule
